// File: design/ivsa_pkg.sv
// ----------------------------------------------------------------------------
// Interrupt vector stack allocator package
// Shared codes, reset values and the result record of the allocator.
// ----------------------------------------------------------------------------
package ivsa_pkg;

  localparam int TOTAL_RESET    = 256;
  localparam int RESERVED_RESET = 1;
  localparam int COUNT_MAX      = 511;
  localparam int SLOT_W         = 13;

  localparam logic REG_TOTAL    = 1'b0;
  localparam logic REG_RESERVED = 1'b1;

  typedef enum logic [1:0] {
    ACT_INIT    = 2'd0,
    ACT_RELEASE = 2'd1,
    ACT_ALLOC   = 2'd2,
    ACT_DEFAULT = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    STS_OK           = 3'd0,
    STS_REFUSED      = 3'd1,
    STS_NONE_FREE    = 3'd2,
    STS_SKIPPED      = 3'd3,
    STS_OUT_OF_RANGE = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_RESP
  } state_t;

  typedef struct packed {
    logic [7:0] granted_index;
    status_t    status;
    logic [8:0] available_count;
  } ivsa_result_t;

endpackage

// File: design/ivsa_store.sv
// ----------------------------------------------------------------------------
// Index store
// Single-port-write, single-port-read memory holding the free vector pool.
// ----------------------------------------------------------------------------
module ivsa_store #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/ivsa_ctrl.sv
// ----------------------------------------------------------------------------
// Allocator controller
// Holds the stack pointers, sequences the store refill and performs the
// read or write of each request against the index store.
// ----------------------------------------------------------------------------
module ivsa_ctrl #(
  parameter int MAX_VECTORS              = 256,
  parameter int VECTORS_PER_DEFAULT_PORT = 1,
  parameter int MAILBOX_VECTORS          = 1,
  parameter int AW                       = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   req_valid,
  output logic                   req_ready,
  input  logic [1:0]             action,
  input  logic [7:0]             vector_index,
  input  logic                   is_default_port,
  input  logic [7:0]             port_number,
  input  logic [7:0]             element_position,
  input  logic [8:0]             total_vectors,
  input  logic [8:0]             reserved_vectors,
  output logic                   res_valid,
  input  logic                   res_ready,
  output ivsa_pkg::ivsa_result_t res,
  output logic                   mem_we,
  output logic [AW-1:0]          mem_waddr,
  output logic [7:0]             mem_wdata,
  output logic                   mem_re,
  output logic [AW-1:0]          mem_raddr,
  input  logic [7:0]             mem_rdata
);

  import ivsa_pkg::*;

  localparam int PW = $clog2(MAX_VECTORS + 1);
  localparam int WW = (PW > 9) ? PW : 9;
  localparam int SW = (PW > SLOT_W) ? PW : SLOT_W;
  localparam int RST_LIMIT = (TOTAL_RESET > MAX_VECTORS) ? MAX_VECTORS : TOTAL_RESET;
  localparam int RST_BASE  = (RESERVED_RESET > RST_LIMIT) ? RST_LIMIT : RESERVED_RESET;

  state_t        state;
  state_t        state_next;
  logic [AW-1:0] clr_cnt;
  logic          reply;
  logic [PW-1:0] limit;
  logic [PW-1:0] base;
  logic [PW-1:0] top;
  status_t       res_status;
  logic          from_mem;

  logic [WW-1:0] tot_w;
  logic [WW-1:0] lim_w;
  logic [WW-1:0] rsv_w;
  logic [WW-1:0] bas_w;
  logic [WW-1:0] diff_w;
  logic [SW-1:0] slot;
  logic          accept;
  logic          clr_last;
  logic          rel_skip;
  logic          rel_refuse;
  logic          alloc_empty;
  logic          dflt_bad;

  assign tot_w  = WW'(total_vectors);
  assign lim_w  = (tot_w > WW'(MAX_VECTORS)) ? WW'(MAX_VECTORS) : tot_w;
  assign rsv_w  = WW'(reserved_vectors);
  assign bas_w  = (rsv_w > lim_w) ? lim_w : rsv_w;

  assign slot = SW'(port_number) * SW'(VECTORS_PER_DEFAULT_PORT)
              + SW'(MAILBOX_VECTORS) + SW'(element_position);

  assign accept      = (state == S_IDLE) && req_valid;
  assign clr_last    = (clr_cnt == AW'(MAX_VECTORS - 1));
  assign rel_skip    = is_default_port && (element_position < 8'(VECTORS_PER_DEFAULT_PORT));
  assign rel_refuse  = (top <= base);
  assign alloc_empty = (top >= limit);
  assign dflt_bad    = (element_position >= 8'(VECTORS_PER_DEFAULT_PORT))
                    || (slot >= SW'(base));

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (clr_last) begin
          state_next = reply ? S_RESP : S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_valid) begin
          state_next = (action == ACT_INIT) ? S_CLEAR : S_RESP;
        end
      end
      S_RESP: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    req_ready = 1'b0;
    res_valid = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = clr_cnt;
    mem_wdata = 8'(clr_cnt);
    mem_re    = 1'b0;
    mem_raddr = AW'(top);
    case (state)
      S_CLEAR: begin
        mem_we = 1'b1;
      end
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          case (action)
            ACT_RELEASE: begin
              mem_we    = !rel_skip && !rel_refuse;
              mem_waddr = AW'(top - PW'(1));
              mem_wdata = vector_index;
            end
            ACT_ALLOC: begin
              mem_re = !alloc_empty;
            end
            ACT_DEFAULT: begin
              mem_re    = !dflt_bad;
              mem_raddr = AW'(slot);
            end
            default: begin
            end
          endcase
        end
      end
      S_RESP: begin
        res_valid = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
      reply   <= 1'b0;
      limit   <= PW'(RST_LIMIT);
      base    <= PW'(RST_BASE);
      top     <= PW'(RST_BASE);
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_cnt <= clr_cnt + AW'(1);
      end
      if (accept) begin
        case (action)
          ACT_INIT: begin
            limit   <= PW'(lim_w);
            base    <= PW'(bas_w);
            top     <= PW'(bas_w);
            clr_cnt <= '0;
            reply   <= 1'b1;
          end
          ACT_RELEASE: begin
            if (!rel_skip && !rel_refuse) begin
              top <= top - PW'(1);
            end
          end
          ACT_ALLOC: begin
            if (!alloc_empty) begin
              top <= top + PW'(1);
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      case (action)
        ACT_RELEASE: begin
          from_mem <= 1'b0;
          if (rel_skip) begin
            res_status <= STS_SKIPPED;
          end else if (rel_refuse) begin
            res_status <= STS_REFUSED;
          end else begin
            res_status <= STS_OK;
          end
        end
        ACT_ALLOC: begin
          if (alloc_empty) begin
            res_status <= STS_NONE_FREE;
            from_mem   <= 1'b0;
          end else begin
            res_status <= STS_OK;
            from_mem   <= 1'b1;
          end
        end
        ACT_DEFAULT: begin
          if (dflt_bad) begin
            res_status <= STS_OUT_OF_RANGE;
            from_mem   <= 1'b0;
          end else begin
            res_status <= STS_OK;
            from_mem   <= 1'b1;
          end
        end
        default: begin
          res_status <= STS_OK;
          from_mem   <= 1'b0;
        end
      endcase
    end
  end

  assign diff_w = WW'(limit - top);

  always_comb begin
    res.granted_index   = from_mem ? mem_rdata : 8'd0;
    res.status          = res_status;
    res.available_count = (diff_w > WW'(COUNT_MAX)) ? 9'(COUNT_MAX) : 9'(diff_w);
  end

endmodule

// File: design/interrupt_vector_stack_allocator_core.sv
// ----------------------------------------------------------------------------
// Interrupt vector stack allocator
// Hands out and takes back interrupt vector numbers from a LIFO free pool.
// Release, allocate and take-default are handled one request at a time; the
// store is read or written on acceptance, then the result register is loaded.
// Init refills the store one entry a cycle. After reset the same refill pass
// runs, during which no request is accepted; configuration writes are
// accepted at all times.
// ----------------------------------------------------------------------------
module interrupt_vector_stack_allocator_core #(
  parameter int MAX_VECTORS              = 256,
  parameter int VECTORS_PER_DEFAULT_PORT = 1,
  parameter int MAILBOX_VECTORS          = 1
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] action,
  input  logic [7:0] vector_index,
  input  logic       is_default_port,
  input  logic [7:0] port_number,
  input  logic [7:0] element_position,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] granted_index,
  output logic [2:0] status,
  output logic [8:0] available_count,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [8:0] cfg_data
);

  import ivsa_pkg::*;

  localparam int AW = $clog2(MAX_VECTORS);

  logic [8:0]   total_vectors;
  logic [8:0]   reserved_vectors;
  logic         res_valid;
  logic         res_ready;
  ivsa_result_t res;
  ivsa_result_t out_q;
  logic         mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]   mem_wdata;
  logic         mem_re;
  logic [AW-1:0] mem_raddr;
  logic [7:0]   mem_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      total_vectors    <= 9'(TOTAL_RESET);
      reserved_vectors <= 9'(RESERVED_RESET);
    end else if (cfg_valid) begin
      if (cfg_index == REG_TOTAL) begin
        total_vectors <= cfg_data;
      end else if (cfg_index == REG_RESERVED) begin
        reserved_vectors <= cfg_data;
      end
    end
  end

  ivsa_ctrl #(
    .MAX_VECTORS              (MAX_VECTORS),
    .VECTORS_PER_DEFAULT_PORT (VECTORS_PER_DEFAULT_PORT),
    .MAILBOX_VECTORS          (MAILBOX_VECTORS),
    .AW                       (AW)
  ) u_ctrl (
    .clk              (clk),
    .rst              (rst),
    .req_valid        (in_valid),
    .req_ready        (in_ready),
    .action           (action),
    .vector_index     (vector_index),
    .is_default_port  (is_default_port),
    .port_number      (port_number),
    .element_position (element_position),
    .total_vectors    (total_vectors),
    .reserved_vectors (reserved_vectors),
    .res_valid        (res_valid),
    .res_ready        (res_ready),
    .res              (res),
    .mem_we           (mem_we),
    .mem_waddr        (mem_waddr),
    .mem_wdata        (mem_wdata),
    .mem_re           (mem_re),
    .mem_raddr        (mem_raddr),
    .mem_rdata        (mem_rdata)
  );

  ivsa_store #(
    .DEPTH (MAX_VECTORS),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign granted_index   = out_q.granted_index;
  assign status          = out_q.status;
  assign available_count = out_q.available_count;

  // A request is handled alone, so the input side closes after a transaction.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while another is in progress");

  assert property (@(posedge clk) disable iff (rst)
    res_valid && res_ready |=> out_valid)
    else $error("result lost on its way to the output register");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == STS_REFUSED || status == STS_NONE_FREE ||
                  status == STS_SKIPPED || status == STS_OUT_OF_RANGE)
    |-> granted_index == 8'd0)
    else $error("failed request carries a vector number");

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Interrupt vector stack allocator testbench
// Drives release, allocate, take-default and init requests through the
// valid/ready request channel under several pool settings. Each response is
// checked against a behavioural model of the free-vector stack.
// ----------------------------------------------------------------------------
module tb;
  import ivsa_pkg::*;

  localparam int MAXV          = 256;
  localparam int PER_PORT      = 1;
  localparam int MAILBOX       = 1;
  localparam int PHASES        = 12;
  localparam int PHASE_ITEMS   = 125;
  localparam int STALL_LIMIT   = 3000;
  localparam int DRAIN_CYCLES  = 300;

  typedef struct {
    action_t    act;
    logic [7:0] vec;
    logic       dflt;
    logic [7:0] port;
    logic [7:0] pos;
  } vec_request_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  action_t    action = ACT_INIT;
  logic [7:0] vector_index = '0;
  logic       is_default_port = 1'b0;
  logic [7:0] port_number = '0;
  logic [7:0] element_position = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] granted_index;
  logic [2:0] status;
  logic [8:0] available_count;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       cfg_index = REG_TOTAL;
  logic [8:0] cfg_data = '0;

  vec_request_t request_q[$];
  ivsa_result_t grant_expect_q[$];

  logic [7:0] pool_store [MAXV];
  int pool_top, pool_base, pool_limit;
  int total_reg, reserved_reg;

  int  mismatch_count = 0;
  int  stall_cycles = 0;
  int  send_wait = 0;
  int  recv_wait = 0;
  bit  send_quiet = 1'b0;
  bit  recv_quiet = 1'b0;

  int cfg_total_set [PHASES] = '{256, 1, 0, 511, 300, 256, 16, 8, 64, 256, 0, 0};
  int cfg_reserved_set [PHASES] = '{0, 0, 5, 511, 255, 256, 0, 2, 70, 128, 0, 0};

  interrupt_vector_stack_allocator_core #(
    .MAX_VECTORS              (MAXV),
    .VECTORS_PER_DEFAULT_PORT (PER_PORT),
    .MAILBOX_VECTORS          (MAILBOX)
  ) i_dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .action           (action),
    .vector_index     (vector_index),
    .is_default_port  (is_default_port),
    .port_number      (port_number),
    .element_position (element_position),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .granted_index    (granted_index),
    .status           (status),
    .available_count  (available_count),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void refill_pool();
    for (int i = 0; i < MAXV; i++) pool_store[i] = i[7:0];
    pool_limit = (total_reg > MAXV) ? MAXV : total_reg;
    pool_base  = (reserved_reg > pool_limit) ? pool_limit : reserved_reg;
    pool_top   = pool_base;
  endfunction

  function automatic ivsa_result_t predict_grant(action_t act, logic [7:0] vec, logic dflt,
                                                 logic [7:0] port, logic [7:0] pos);
    ivsa_result_t r;
    int slot;
    int cnt;
    r.granted_index = '0;
    r.status = STS_OK;
    case (act)
      ACT_INIT: begin
        refill_pool();
      end
      ACT_RELEASE: begin
        if (dflt && pos < PER_PORT) begin
          r.status = STS_SKIPPED;
        end else if (pool_top <= pool_base || pool_top == 0) begin
          r.status = STS_REFUSED;
        end else begin
          pool_top--;
          if (pool_top < MAXV) pool_store[pool_top] = vec;
        end
      end
      ACT_ALLOC: begin
        if (pool_top >= pool_limit || pool_top >= MAXV) begin
          r.status = STS_NONE_FREE;
        end else begin
          r.granted_index = pool_store[pool_top];
          pool_top++;
        end
      end
      default: begin
        slot = int'(port) * PER_PORT + MAILBOX + int'(pos);
        if (pos >= PER_PORT || slot >= pool_base || slot >= MAXV) begin
          r.status = STS_OUT_OF_RANGE;
        end else begin
          r.granted_index = pool_store[slot];
        end
      end
    endcase
    cnt = (pool_limit > pool_top) ? pool_limit - pool_top : 0;
    if (cnt > COUNT_MAX) cnt = COUNT_MAX;
    r.available_count = cnt[8:0];
    return r;
  endfunction

  function automatic int draw_gap(bit quiet);
    return quiet ? 0 : int'($urandom_range(0, 5));
  endfunction

  task automatic queue_request(action_t a, logic [7:0] v, logic d, logic [7:0] p,
                               logic [7:0] e);
    vec_request_t req;
    req.act  = a;
    req.vec  = v;
    req.dflt = d;
    req.port = p;
    req.pos  = e;
    request_q.push_back(req);
  endtask

  task automatic wait_idle();
    while (request_q.size() != 0 || in_valid || grant_expect_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [8:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_TOTAL) total_reg = val;
    else reserved_reg = val;
  endtask

  // Request driver: a transaction is presented after the drawn gap and held
  // until it is accepted.
  always @(posedge clk) begin : request_side
    vec_request_t req;
    if (rst) begin
      in_valid  <= 1'b0;
      send_wait <= 0;
    end else begin
      if (in_valid && in_ready) begin
        grant_expect_q.push_back(predict_grant(action, vector_index, is_default_port,
                                               port_number, element_position));
      end
      if (!in_valid || in_ready) begin
        if (send_wait != 0) begin
          send_wait <= send_wait - 1;
          in_valid  <= 1'b0;
        end else if (request_q.size() != 0) begin
          req = request_q.pop_front();
          action           <= req.act;
          vector_index     <= req.vec;
          is_default_port  <= req.dflt;
          port_number      <= req.port;
          element_position <= req.pos;
          in_valid         <= 1'b1;
          send_wait        <= draw_gap(send_quiet);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Response monitor with a randomly stalling ready.
  always @(posedge clk) begin : response_side
    ivsa_result_t exp_r;
    int nxt;
    if (rst) begin
      out_ready <= 1'b0;
      recv_wait <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (grant_expect_q.size() == 0) begin
          $display("%0t: unexpected transaction, granted_index %0d status %0d count %0d",
                   $time, granted_index, status, available_count);
          mismatch_count++;
        end else begin
          exp_r = grant_expect_q.pop_front();
          if (granted_index !== exp_r.granted_index) begin
            $display("%0t: granted_index expected %0d actual %0d",
                     $time, exp_r.granted_index, granted_index);
            mismatch_count++;
          end
          if (status !== exp_r.status) begin
            $display("%0t: status expected %0d actual %0d", $time, exp_r.status, status);
            mismatch_count++;
          end
          if (available_count !== exp_r.available_count) begin
            $display("%0t: available_count expected %0d actual %0d",
                     $time, exp_r.available_count, available_count);
            mismatch_count++;
          end
        end
        nxt = draw_gap(recv_quiet);
      end else begin
        nxt = (recv_wait > 0) ? recv_wait - 1 : 0;
      end
      recv_wait <= nxt;
      out_ready <= (nxt == 0);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin : stimulus
    int alloc_pct;
    int pick;
    vec_request_t req;
    total_reg    = TOTAL_RESET;
    reserved_reg = RESERVED_RESET;
    refill_pool();

    // Reset settings: pops, a push and pop of extreme vector numbers, the
    // default-slot skip and a refusal at the base.
    queue_request(ACT_ALLOC,   8'h00, 1'b0, 8'h00, 8'h00);
    queue_request(ACT_ALLOC,   8'h00, 1'b0, 8'h00, 8'h00);
    queue_request(ACT_RELEASE, 8'hFF, 1'b0, 8'h00, 8'h00);
    queue_request(ACT_ALLOC,   8'h00, 1'b0, 8'h00, 8'h00);
    queue_request(ACT_RELEASE, 8'h12, 1'b1, 8'h00, 8'h00);
    queue_request(ACT_RELEASE, 8'h00, 1'b1, 8'hFF, 8'hFF);
    queue_request(ACT_DEFAULT, 8'h00, 1'b1, 8'h00, 8'h00);
    queue_request(ACT_DEFAULT, 8'hFF, 1'b1, 8'hFF, 8'hFF);
    queue_request(ACT_INIT,    8'h00, 1'b0, 8'h00, 8'h00);
    queue_request(ACT_RELEASE, 8'hAA, 1'b0, 8'h00, 8'h00);

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    wait_idle();

    // A small pool with three reserved slots: default reads, exhaustion and a
    // refused push at the base.
    write_reg(REG_TOTAL, 9'd4);
    write_reg(REG_RESERVED, 9'd3);
    queue_request(ACT_INIT,    8'h00, 1'b0, 8'h00, 8'h00);
    queue_request(ACT_DEFAULT, 8'h00, 1'b1, 8'h00, 8'h00);
    queue_request(ACT_DEFAULT, 8'h00, 1'b1, 8'h01, 8'h00);
    queue_request(ACT_DEFAULT, 8'h00, 1'b1, 8'h02, 8'h00);
    queue_request(ACT_DEFAULT, 8'h00, 1'b1, 8'h00, 8'h01);
    queue_request(ACT_ALLOC,   8'h00, 1'b0, 8'h00, 8'h00);
    queue_request(ACT_ALLOC,   8'h00, 1'b0, 8'h00, 8'h00);
    queue_request(ACT_RELEASE, 8'h55, 1'b0, 8'h00, 8'h00);
    queue_request(ACT_RELEASE, 8'h33, 1'b0, 8'h00, 8'h00);
    queue_request(ACT_ALLOC,   8'h00, 1'b0, 8'h00, 8'h00);
    wait_idle();

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph >= PHASES - 2) begin
        cfg_total_set[ph]    = int'($urandom_range(0, 511));
        cfg_reserved_set[ph] = int'($urandom_range(0, 511));
      end
      write_reg(REG_TOTAL, cfg_total_set[ph][8:0]);
      write_reg(REG_RESERVED, cfg_reserved_set[ph][8:0]);
      send_quiet = ($urandom_range(0, 3) == 0);
      recv_quiet = ($urandom_range(0, 3) == 0);
      alloc_pct  = int'($urandom_range(20, 80));
      if ($urandom_range(0, 3) != 0) queue_request(ACT_INIT, 8'h00, 1'b0, 8'h00, 8'h00);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = int'($urandom_range(0, 99));
        if (pick < 2) req.act = ACT_INIT;
        else if (pick < 20) req.act = ACT_DEFAULT;
        else if ($urandom_range(0, 99) < alloc_pct) req.act = ACT_ALLOC;
        else req.act = ACT_RELEASE;
        req.vec  = 8'($urandom_range(0, 255));
        req.dflt = 1'($urandom_range(0, 1));
        req.port = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                               : 8'($urandom_range(0, 7));
        req.pos  = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                               : 8'($urandom_range(0, 2));
        request_q.push_back(req);
      end
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && grant_expect_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
